FILE: src/cnsq_pkg.sv
// Shared types, constants and the microcode table of the LCD nibble bus sequencer.
package cnsq_pkg;

    // Command operation codes
    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_CURSOR = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_DISPLAY_STYLE = 3'd0;
    localparam logic [2:0] REG_SETTLE        = 3'd1;
    localparam logic [2:0] REG_BASE_DELAY    = 3'd2;
    localparam logic [2:0] REG_CMD_EXTRA     = 3'd3;
    localparam logic [2:0] REG_CLEAR_WAIT    = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int HOLD_W      = 18;
    localparam int PC_W        = 5;

    // Configuration reset values
    localparam logic [1:0]  RST_DISPLAY_STYLE = 2'd0;
    localparam logic [7:0]  RST_SETTLE        = 8'd1;
    localparam logic [7:0]  RST_BASE_DELAY    = 8'd37;
    localparam logic [9:0]  RST_CMD_EXTRA     = 10'd450;
    localparam logic [15:0] RST_CLEAR_WAIT    = 16'd1500;

    // Fixed LCD bytes and power-on waits
    localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] LCD_CLEAR        = 8'h01;
    localparam logic [3:0] NIB_WAKE         = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;
    localparam logic [HOLD_W-1:0] WAIT_POWER_ON = 18'd40000;
    localparam logic [HOLD_W-1:0] WAIT_WAKE1    = 18'd4100;
    localparam logic [HOLD_W-1:0] WAIT_WAKE2    = 18'd100;

    // Init byte sequence index of the closing clear
    localparam logic [1:0] INIT_LAST_SEQ = 2'd3;

    // Entry points of the init and shared byte-write routines, and the last program step
    localparam logic [PC_W-1:0] PC_INIT = 5'd0;
    localparam logic [PC_W-1:0] PC_BYTE = 5'd11;
    localparam logic [PC_W-1:0] PC_LAST = 5'd16;

    // Nibble source
    localparam logic [1:0] NIB_CONST = 2'd0;
    localparam logic [1:0] NIB_HIGH  = 2'd1;
    localparam logic [1:0] NIB_LOW   = 2'd2;

    // Hold source
    localparam logic [2:0] H_ZERO   = 3'd0;
    localparam logic [2:0] H_SETTLE = 3'd1;
    localparam logic [2:0] H_POWER  = 3'd2;
    localparam logic [2:0] H_WAKE1  = 3'd3;
    localparam logic [2:0] H_WAKE2  = 3'd4;
    localparam logic [2:0] H_WAIT   = 3'd5;
    localparam logic [2:0] H_TAIL   = 3'd6;

    // Sequencing
    localparam logic [1:0] J_NEXT = 2'd0;
    localparam logic [1:0] J_END  = 2'd1;
    localparam logic [1:0] J_LOOP = 2'd2;

    typedef struct packed {
        logic [1:0] nib_sel;
        logic [3:0] nib_const;
        logic       en;
        logic [2:0] hold_sel;
        logic [1:0] jump;
    } ctrl_word_t;

    typedef struct packed {
        logic [1:0]  display_style;
        logic [7:0]  settle_us;
        logic [7:0]  base_delay_us;
        logic [9:0]  command_extra_count;
        logic [15:0] clear_wait_us;
    } cfg_t;

    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            5'd0:    w = '{NIB_CONST, 4'h0,         1'b0, H_POWER,  J_NEXT};
            5'd1:    w = '{NIB_CONST, NIB_WAKE,     1'b1, H_SETTLE, J_NEXT};
            5'd2:    w = '{NIB_CONST, NIB_WAKE,     1'b0, H_WAKE1,  J_NEXT};
            5'd3:    w = '{NIB_CONST, NIB_WAKE,     1'b1, H_SETTLE, J_NEXT};
            5'd4:    w = '{NIB_CONST, NIB_WAKE,     1'b0, H_WAKE2,  J_NEXT};
            5'd5:    w = '{NIB_CONST, NIB_WAKE,     1'b1, H_SETTLE, J_NEXT};
            5'd6:    w = '{NIB_CONST, NIB_WAKE,     1'b0, H_WAKE2,  J_NEXT};
            5'd7:    w = '{NIB_CONST, NIB_WAKE,     1'b1, H_ZERO,   J_NEXT};
            5'd8:    w = '{NIB_CONST, NIB_FOUR_BIT, 1'b1, H_SETTLE, J_NEXT};
            5'd9:    w = '{NIB_CONST, NIB_FOUR_BIT, 1'b0, H_WAKE2,  J_NEXT};
            5'd10:   w = '{NIB_CONST, NIB_FOUR_BIT, 1'b1, H_ZERO,   J_NEXT};
            5'd11:   w = '{NIB_HIGH,  4'h0,         1'b1, H_SETTLE, J_NEXT};
            5'd12:   w = '{NIB_HIGH,  4'h0,         1'b0, H_ZERO,   J_NEXT};
            5'd13:   w = '{NIB_HIGH,  4'h0,         1'b1, H_ZERO,   J_NEXT};
            5'd14:   w = '{NIB_LOW,   4'h0,         1'b1, H_SETTLE, J_NEXT};
            5'd15:   w = '{NIB_LOW,   4'h0,         1'b0, H_WAIT,   J_NEXT};
            5'd16:   w = '{NIB_LOW,   4'h0,         1'b1, H_TAIL,   J_LOOP};
            default: w = '{NIB_CONST, 4'h0,         1'b0, H_ZERO,   J_END};
        endcase
        return w;
    endfunction

    // Setup bytes played after the power-on nibbles
    function automatic logic [7:0] init_byte(input logic [1:0] idx, input logic [1:0] style);
        logic [7:0] b;
        case (idx)
            2'd0:    b = LCD_FUNCTION_SET;
            2'd1:    b = LCD_DISPLAY_ON | {6'd0, style};
            2'd2:    b = LCD_ENTRY_MODE;
            default: b = LCD_CLEAR;
        endcase
        return b;
    endfunction

endpackage

FILE: src/cnsq_cmd_if.sv
// Command channel interface of the LCD nibble bus sequencer.
interface cnsq_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic       reg_select;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic       line_sel;

    modport source (output valid, operation, reg_select, byte_value, column, line_sel,
                    input ready);
    modport sink   (input valid, operation, reg_select, byte_value, column, line_sel,
                    output ready);
endinterface

FILE: src/cnsq_phase_if.sv
// Pin phase result channel interface of the LCD nibble bus sequencer.
interface cnsq_phase_if;
    logic        valid;
    logic        ready;
    logic [3:0]  bus_nibble;
    logic        rs_level;
    logic        enable_level;
    logic [17:0] hold_us;
    logic        last_phase;

    modport source (output valid, bus_nibble, rs_level, enable_level, hold_us, last_phase,
                    input ready);
    modport sink   (input valid, bus_nibble, rs_level, enable_level, hold_us, last_phase,
                    output ready);
endinterface

FILE: src/cnsq_cfg_if.sv
// Configuration write channel interface of the LCD nibble bus sequencer.
interface cnsq_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [15:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

FILE: src/cnsq_hold_sel.sv
// Hold time selection for one phase, including the command processing wait product.
module cnsq_hold_sel (
    input  cnsq_pkg::cfg_t                   cfg,
    input  logic [2:0]                       hold_sel,
    input  logic                             rs,
    input  logic                             clr,
    output logic [cnsq_pkg::HOLD_W-1:0]      hold
);

    logic [10:0] factor;
    logic [18:0] product;

    // Command writes wait base * (1 + extra), data writes just base
    assign factor  = rs ? 11'd1 : ({1'b0, cfg.command_extra_count} + 11'd1);
    assign product = {11'd0, cfg.base_delay_us} * {8'd0, factor};

    always_comb
    begin
        case (hold_sel)
            cnsq_pkg::H_ZERO:   hold = '0;
            cnsq_pkg::H_SETTLE: hold = {10'd0, cfg.settle_us};
            cnsq_pkg::H_POWER:  hold = cnsq_pkg::WAIT_POWER_ON;
            cnsq_pkg::H_WAKE1:  hold = cnsq_pkg::WAIT_WAKE1;
            cnsq_pkg::H_WAKE2:  hold = cnsq_pkg::WAIT_WAKE2;
            cnsq_pkg::H_WAIT:   hold = product[17:0];
            cnsq_pkg::H_TAIL:   hold = clr ? {2'd0, cfg.clear_wait_us} : '0;
            default:            hold = '0;
        endcase
    end

endmodule

FILE: src/char_lcd_nibble_bus_sequencer_core.sv
// Top level of the character LCD 4-bit bus sequencer.
//
// Usage: each transaction on cmd (init, write byte, clear, move cursor) expands
// into a run of pin phases on phase: nibble, register select, enable level and
// a hold time in microseconds. The final phase of a run has last_phase set.
// Write byte, clear and move cursor give 6 phases; init gives 35.
// Timing: after cmd is accepted the step counter is loaded and the first phase is
// then registered; further phases follow one per cycle while phase.ready is high.
// cmd.ready rises in the cycle the last phase is registered, and the next command
// can be accepted from then on. The microcode step counter issues one control
// word per cycle while phase.ready is high.
// cfg writes registers 0..4; the user must write only while the block is idle,
// which the block itself does not enforce. cfg.ready stays high and writes to
// other indexes are dropped. When phase.ready is low with a phase registered, the
// sequencer holds on the current step and that phase holds. Reset clears the step
// counter and the output valid and restores the configuration defaults.
module char_lcd_nibble_bus_sequencer_core (
    input  logic               clk,
    input  logic               rst_n,
    cnsq_cmd_if.sink           cmd,
    cnsq_phase_if.source       phase,
    cnsq_cfg_if.sink           cfg
);

    cnsq_pkg::cfg_t             cfg_reg;
    cnsq_pkg::ctrl_word_t       word;

    logic                       busy_reg;
    logic                       init_reg;
    logic [cnsq_pkg::PC_W-1:0]  pc_reg;
    logic [1:0]                 seq_reg;
    logic [7:0]                 dat_reg;
    logic                       rs_reg;
    logic                       clr_reg;

    logic                       ovalid_reg;
    logic [3:0]                 nib_reg;
    logic                       rsout_reg;
    logic                       en_reg;
    logic [cnsq_pkg::HOLD_W-1:0] hold_reg;
    logic                       last_reg;

    logic                       accept;
    logic                       fire;
    logic                       loop_take;
    logic                       done;
    logic [1:0]                 seq_next;
    logic [3:0]                 nib_next;
    logic [cnsq_pkg::HOLD_W-1:0] hold_next;

    assign cmd.ready = !busy_reg;
    assign cfg.ready = 1'b1;
    assign accept    = cmd.valid && !busy_reg;
    assign fire      = busy_reg && (!ovalid_reg || phase.ready);

    assign word      = cnsq_pkg::ucode(pc_reg);
    assign loop_take = init_reg && (seq_reg != cnsq_pkg::INIT_LAST_SEQ);
    assign done      = (word.jump == cnsq_pkg::J_END)
                    || ((word.jump == cnsq_pkg::J_LOOP) && !loop_take);
    assign seq_next  = seq_reg + 2'd1;

    always_comb
    begin
        case (word.nib_sel)
            cnsq_pkg::NIB_HIGH: nib_next = dat_reg[7:4];
            cnsq_pkg::NIB_LOW:  nib_next = dat_reg[3:0];
            default:            nib_next = word.nib_const;
        endcase
    end

    cnsq_hold_sel u_hold (
        .cfg      (cfg_reg),
        .hold_sel (word.hold_sel),
        .rs       (rs_reg),
        .clr      (clr_reg),
        .hold     (hold_next)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_style       <= cnsq_pkg::RST_DISPLAY_STYLE;
            cfg_reg.settle_us           <= cnsq_pkg::RST_SETTLE;
            cfg_reg.base_delay_us       <= cnsq_pkg::RST_BASE_DELAY;
            cfg_reg.command_extra_count <= cnsq_pkg::RST_CMD_EXTRA;
            cfg_reg.clear_wait_us       <= cnsq_pkg::RST_CLEAR_WAIT;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                cnsq_pkg::REG_DISPLAY_STYLE: cfg_reg.display_style       <= cfg.wr_data[1:0];
                cnsq_pkg::REG_SETTLE:        cfg_reg.settle_us           <= cfg.wr_data[7:0];
                cnsq_pkg::REG_BASE_DELAY:    cfg_reg.base_delay_us       <= cfg.wr_data[7:0];
                cnsq_pkg::REG_CMD_EXTRA:     cfg_reg.command_extra_count <= cfg.wr_data[9:0];
                cnsq_pkg::REG_CLEAR_WAIT:    cfg_reg.clear_wait_us       <= cfg.wr_data;
                default:                     ;
            endcase
        end
    end

    // Step counter and byte datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            init_reg <= 1'b0;
            pc_reg   <= cnsq_pkg::PC_INIT;
            seq_reg  <= 2'd0;
            dat_reg  <= 8'd0;
            rs_reg   <= 1'b0;
            clr_reg  <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            seq_reg  <= 2'd0;
            init_reg <= (cmd.operation == cnsq_pkg::OP_INIT);
            case (cmd.operation)
                cnsq_pkg::OP_INIT:
                begin
                    pc_reg  <= cnsq_pkg::PC_INIT;
                    dat_reg <= cnsq_pkg::LCD_FUNCTION_SET;
                    rs_reg  <= 1'b0;
                    clr_reg <= 1'b0;
                end
                cnsq_pkg::OP_WRITE:
                begin
                    pc_reg  <= cnsq_pkg::PC_BYTE;
                    dat_reg <= cmd.byte_value;
                    rs_reg  <= cmd.reg_select;
                    clr_reg <= 1'b0;
                end
                cnsq_pkg::OP_CLEAR:
                begin
                    pc_reg  <= cnsq_pkg::PC_BYTE;
                    dat_reg <= cnsq_pkg::LCD_CLEAR;
                    rs_reg  <= 1'b0;
                    clr_reg <= 1'b1;
                end
                default:
                begin
                    pc_reg  <= cnsq_pkg::PC_BYTE;
                    dat_reg <= {1'b1, cmd.line_sel, cmd.column};
                    rs_reg  <= 1'b0;
                    clr_reg <= 1'b0;
                end
            endcase
        end
        else if (fire)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            else if (word.jump == cnsq_pkg::J_LOOP)
            begin
                // Rerun the byte routine with the next setup byte
                pc_reg  <= cnsq_pkg::PC_BYTE;
                seq_reg <= seq_next;
                dat_reg <= cnsq_pkg::init_byte(seq_next, cfg_reg.display_style);
                clr_reg <= (seq_next == cnsq_pkg::INIT_LAST_SEQ);
            end
            else
            begin
                pc_reg <= pc_reg + 5'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else if (fire)
        begin
            ovalid_reg <= 1'b1;
            last_reg   <= done;
        end
        else if (phase.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            nib_reg   <= nib_next;
            rsout_reg <= rs_reg;
            en_reg    <= word.en;
            hold_reg  <= hold_next;
        end
    end

    assign phase.valid        = ovalid_reg;
    assign phase.bus_nibble   = nib_reg;
    assign phase.rs_level     = rsout_reg;
    assign phase.enable_level = en_reg;
    assign phase.hold_us      = hold_reg;
    assign phase.last_phase   = last_reg;

`ifndef SYNTHESIS
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= cnsq_pkg::PC_LAST))
        else $error("step counter outside program");

    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !last_reg) |-> busy_reg)
        else $error("run ended without a last phase");

    a_seq_init: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !init_reg) |-> (seq_reg == 2'd0))
        else $error("setup byte index moved outside init");

    a_data_rs: assert property (@(posedge clk) disable iff (!rst_n)
        rs_reg |-> (!clr_reg && !init_reg))
        else $error("data register select on a command sequence");
`endif

endmodule

FILE: tb/sv/cnsq_tb_pkg.sv
`timescale 1ns / 1ps
// Command and phase types plus the phase scoreboard for the LCD nibble bus sequencer bench.
package cnsq_tb_pkg;
    import cnsq_pkg::*;

    // Set-DDRAM-address command byte used by move cursor
    localparam logic [7:0] LCD_SET_ADDRESS = 8'h80;

    typedef struct {
        logic [1:0] operation;
        logic       reg_select;
        logic [7:0] byte_value;
        logic [5:0] column;
        logic       line_sel;
    } lcd_cmd_t;

    typedef struct {
        logic [3:0]        bus_nibble;
        logic              rs_level;
        logic              enable_level;
        logic [HOLD_W-1:0] hold_us;
        logic              last_phase;
    } pin_phase_t;

    class lcd_phase_scoreboard;
        cfg_t       regs;
        pin_phase_t expected_phases[$];
        int         op_count[4];
        int         phases_checked;
        int         mismatches;

        function new();
            regs.display_style       = RST_DISPLAY_STYLE;
            regs.settle_us           = RST_SETTLE;
            regs.base_delay_us       = RST_BASE_DELAY;
            regs.command_extra_count = RST_CMD_EXTRA;
            regs.clear_wait_us       = RST_CLEAR_WAIT;
            foreach (op_count[i])
                op_count[i] = 0;
            phases_checked = 0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DISPLAY_STYLE: regs.display_style       = data[1:0];
                REG_SETTLE:        regs.settle_us           = data[7:0];
                REG_BASE_DELAY:    regs.base_delay_us       = data[7:0];
                REG_CMD_EXTRA:     regs.command_extra_count = data[9:0];
                REG_CLEAR_WAIT:    regs.clear_wait_us       = data;
                default:           ;
            endcase
        endfunction

        function bit busy();
            return expected_phases.size() != 0;
        endfunction

        function void add_phase(logic [3:0] nib, logic rs, logic en, logic [HOLD_W-1:0] hold);
            pin_phase_t p;
            p.bus_nibble   = nib;
            p.rs_level     = rs;
            p.enable_level = en;
            p.hold_us      = hold;
            p.last_phase   = 1'b0;
            expected_phases.push_back(p);
        endfunction

        function logic [HOLD_W-1:0] settle_hold();
            return HOLD_W'(regs.settle_us);
        endfunction

        // High nibble then low nibble; the processing wait follows the low strobe
        function void add_byte_write(logic rs, logic [7:0] b);
            logic [31:0] wait_us;
            wait_us = 32'(regs.base_delay_us);
            if (!rs)
                wait_us = 32'(regs.base_delay_us) * (32'(regs.command_extra_count) + 32'd1);
            add_phase(b[7:4], rs, 1'b1, settle_hold());
            add_phase(b[7:4], rs, 1'b0, '0);
            add_phase(b[7:4], rs, 1'b1, '0);
            add_phase(b[3:0], rs, 1'b1, settle_hold());
            add_phase(b[3:0], rs, 1'b0, wait_us[HOLD_W-1:0]);
            add_phase(b[3:0], rs, 1'b1, '0);
        endfunction

        function void add_clear();
            pin_phase_t p;
            add_byte_write(1'b0, LCD_CLEAR);
            p = expected_phases.pop_back();
            p.hold_us = HOLD_W'(regs.clear_wait_us);
            expected_phases.push_back(p);
        endfunction

        function void note_command(lcd_cmd_t c);
            pin_phase_t p;
            op_count[c.operation]++;
            case (c.operation)
                OP_INIT:
                begin
                    add_phase(4'h0, 1'b0, 1'b0, WAIT_POWER_ON);
                    add_phase(NIB_WAKE, 1'b0, 1'b1, settle_hold());
                    add_phase(NIB_WAKE, 1'b0, 1'b0, WAIT_WAKE1);
                    add_phase(NIB_WAKE, 1'b0, 1'b1, settle_hold());
                    add_phase(NIB_WAKE, 1'b0, 1'b0, WAIT_WAKE2);
                    add_phase(NIB_WAKE, 1'b0, 1'b1, settle_hold());
                    add_phase(NIB_WAKE, 1'b0, 1'b0, WAIT_WAKE2);
                    add_phase(NIB_WAKE, 1'b0, 1'b1, '0);
                    add_phase(NIB_FOUR_BIT, 1'b0, 1'b1, settle_hold());
                    add_phase(NIB_FOUR_BIT, 1'b0, 1'b0, WAIT_WAKE2);
                    add_phase(NIB_FOUR_BIT, 1'b0, 1'b1, '0);
                    add_byte_write(1'b0, LCD_FUNCTION_SET);
                    add_byte_write(1'b0, LCD_DISPLAY_ON | {6'd0, regs.display_style});
                    add_byte_write(1'b0, LCD_ENTRY_MODE);
                    add_clear();
                end
                OP_WRITE:  add_byte_write(c.reg_select, c.byte_value);
                OP_CLEAR:  add_clear();
                OP_CURSOR: add_byte_write(1'b0, LCD_SET_ADDRESS | {1'b0, c.line_sel, c.column});
            endcase
            // Flag the closing phase of this run
            p = expected_phases.pop_back();
            p.last_phase = 1'b1;
            expected_phases.push_back(p);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_phase(pin_phase_t got);
            pin_phase_t want;
            if (expected_phases.size() == 0)
            begin
                $error("unexpected phase: nibble %0h rs %0b en %0b hold %0d last %0b",
                       got.bus_nibble, got.rs_level, got.enable_level, got.hold_us,
                       got.last_phase);
                mismatches++;
                return;
            end
            want = expected_phases.pop_front();
            phases_checked++;
            compare_field("bus_nibble", 32'(want.bus_nibble), 32'(got.bus_nibble));
            compare_field("rs_level", 32'(want.rs_level), 32'(got.rs_level));
            compare_field("enable_level", 32'(want.enable_level), 32'(got.enable_level));
            compare_field("hold_us", 32'(want.hold_us), 32'(got.hold_us));
            compare_field("last_phase", 32'(want.last_phase), 32'(got.last_phase));
        endfunction
    endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top-level bench: drives commands and register writes, stalls the phase sink, checks every phase.
module tb_top;
    import cnsq_pkg::*;
    import cnsq_tb_pkg::*;

    logic clk;
    logic rst_n;
    int   idle_pct = 36;
    int   settings_used = 1;

    lcd_phase_scoreboard sb;

    cnsq_cmd_if   cmd_bus();
    cnsq_phase_if phase_bus();
    cnsq_cfg_if   cfg_bus();

    char_lcd_nibble_bus_sequencer_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .phase (phase_bus),
        .cfg   (cfg_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic bit roll_idle();
        return $urandom_range(99) < idle_pct;
    endfunction

    function automatic lcd_cmd_t make_cmd(logic [1:0] op, logic rs, logic [7:0] b,
                                          logic [5:0] col, logic line);
        lcd_cmd_t c;
        c.operation  = op;
        c.reg_select = rs;
        c.byte_value = b;
        c.column     = col;
        c.line_sel   = line;
        return c;
    endfunction

    function automatic lcd_cmd_t random_command();
        lcd_cmd_t c;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 8)
            c.operation = OP_INIT;
        else if (pick < 66)
            c.operation = OP_WRITE;
        else if (pick < 80)
            c.operation = OP_CLEAR;
        else
            c.operation = OP_CURSOR;
        c.reg_select = 1'($urandom);
        c.byte_value = 8'($urandom);
        c.column     = 6'($urandom);
        c.line_sel   = 1'($urandom);
        return c;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        case ($urandom_range(5))
            0:       s = '0;
            1:       s = '1;
            default:
            begin
                s.display_style       = 2'($urandom);
                s.settle_us           = 8'($urandom);
                s.base_delay_us       = 8'($urandom);
                s.command_extra_count = 10'($urandom);
                s.clear_wait_us       = 16'($urandom);
            end
        endcase
        return s;
    endfunction

    // Hold valid until accepted; leave it high so a following command keeps it up
    task automatic send_command(input lcd_cmd_t c);
        while (roll_idle())
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.operation  <= c.operation;
        cmd_bus.reg_select <= c.reg_select;
        cmd_bus.byte_value <= c.byte_value;
        cmd_bus.column     <= c.column;
        cmd_bus.line_sel   <= c.line_sel;
        do
            @(posedge clk);
        while (cmd_bus.ready !== 1'b1);
        sb.note_command(c);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.wr_data   <= data;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    // Drain phases, maybe write a bad index, then rewrite every register, junk in spare bits
    task automatic apply_settings(input cfg_t s);
        cmd_bus.valid <= 1'b0;
        while (sb.busy())
            @(posedge clk);
        if ($urandom_range(1) == 1)
            write_register(REG_CLEAR_WAIT + 3'($urandom_range(3, 1)), 16'($urandom));
        write_register(REG_DISPLAY_STYLE, {14'($urandom), s.display_style});
        write_register(REG_SETTLE, {8'($urandom), s.settle_us});
        write_register(REG_BASE_DELAY, {8'($urandom), s.base_delay_us});
        write_register(REG_CMD_EXTRA, {6'($urandom), s.command_extra_count});
        write_register(REG_CLEAR_WAIT, s.clear_wait_us);
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    // Phase sink with random back-pressure
    initial
    begin
        pin_phase_t got;
        phase_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase_bus.valid === 1'b1 && phase_bus.ready === 1'b1)
            begin
                got.bus_nibble   = phase_bus.bus_nibble;
                got.rs_level     = phase_bus.rs_level;
                got.enable_level = phase_bus.enable_level;
                got.hold_us      = phase_bus.hold_us;
                got.last_phase   = phase_bus.last_phase;
                sb.check_phase(got);
            end
            phase_bus.ready <= !roll_idle();
        end
    end

    initial
    begin
        sb = new();
        rst_n              <= 1'b0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.operation  <= OP_INIT;
        cmd_bus.reg_select <= 1'b0;
        cmd_bus.byte_value <= '0;
        cmd_bus.column     <= '0;
        cmd_bus.line_sel   <= 1'b0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.reg_index  <= REG_DISPLAY_STYLE;
        cfg_bus.wr_data    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: every operation, nibble extremes, unused fields set
        send_command(make_cmd(OP_INIT, 1'b1, 8'hFF, 6'h3F, 1'b1));
        send_command(make_cmd(OP_WRITE, 1'b0, 8'h00, 6'h00, 1'b0));
        send_command(make_cmd(OP_WRITE, 1'b1, 8'hFF, 6'h00, 1'b0));
        send_command(make_cmd(OP_WRITE, 1'b1, 8'hA5, 6'h3F, 1'b1));
        send_command(make_cmd(OP_WRITE, 1'b0, 8'h5A, 6'h15, 1'b0));
        send_command(make_cmd(OP_CLEAR, 1'b1, 8'hC3, 6'h2A, 1'b1));
        send_command(make_cmd(OP_CURSOR, 1'b1, 8'hFF, 6'h00, 1'b0));
        send_command(make_cmd(OP_CURSOR, 1'b0, 8'h00, 6'h3F, 1'b1));

        // All registers at maximum: largest command wait and full cursor style
        apply_settings('1);
        send_command(make_cmd(OP_WRITE, 1'b0, 8'hFF, 6'h00, 1'b0));
        send_command(make_cmd(OP_INIT, 1'b0, 8'h00, 6'h00, 1'b0));
        send_command(make_cmd(OP_CLEAR, 1'b0, 8'h00, 6'h00, 1'b0));
        send_command(make_cmd(OP_CURSOR, 1'b1, 8'h81, 6'h15, 1'b1));
        send_command(make_cmd(OP_WRITE, 1'b1, 8'h00, 6'h3F, 1'b1));

        // All registers at zero
        apply_settings('0);
        send_command(make_cmd(OP_WRITE, 1'b0, 8'h3C, 6'h00, 1'b0));
        send_command(make_cmd(OP_WRITE, 1'b1, 8'hC3, 6'h00, 1'b0));
        send_command(make_cmd(OP_INIT, 1'b1, 8'h7E, 6'h01, 1'b0));
        send_command(make_cmd(OP_CLEAR, 1'b0, 8'h00, 6'h00, 1'b0));
        send_command(make_cmd(OP_CURSOR, 1'b0, 8'h00, 6'h2A, 1'b0));

        // Random blocks, one register setting each; block 3 runs without any idling
        for (int blk = 0; blk < 7; blk++)
        begin
            apply_settings(random_settings());
            idle_pct = (blk == 3) ? 0 : 36;
            repeat (60) send_command(random_command());
        end

        cmd_bus.valid <= 1'b0;
        while (sb.busy())
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Covered %0d commands (%0d init, %0d write, %0d clear, %0d cursor)",
                 sb.op_count[OP_INIT] + sb.op_count[OP_WRITE] + sb.op_count[OP_CLEAR]
                 + sb.op_count[OP_CURSOR], sb.op_count[OP_INIT], sb.op_count[OP_WRITE],
                 sb.op_count[OP_CLEAR], sb.op_count[OP_CURSOR]);
        $display("and %0d pin phases under %0d register settings, with stalls on both sides",
                 sb.phases_checked, settings_used);
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
src/cnsq_pkg.sv
src/cnsq_cmd_if.sv
src/cnsq_phase_if.sv
src/cnsq_cfg_if.sv
src/cnsq_hold_sel.sv
src/char_lcd_nibble_bus_sequencer_core.sv
tb/sv/cnsq_tb_pkg.sv
tb/sv/tb_top.sv
